[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/uarc_pkg.sv]
package uarc_pkg;

   localparam int MAX_PACKET_BYTES = 9216;
   localparam int POS_WIDTH = $clog2(MAX_PACKET_BYTES + 1);
   localparam int LEN_WIDTH = $clog2(MAX_PACKET_BYTES + 2);
   localparam int CMP_WIDTH = 17;
   localparam int ADDEND_WIDTH = 18;

   localparam int UDP_PROTO = 17;
   localparam int UDP_HDR_BYTES = 8;
   localparam int MIN_LEN_V4 = 28;
   localparam int MIN_LEN_V6 = 48;
   localparam int V6_HDR_LEN = 40;

   localparam logic [3:0] IP_VERSION_V4 = 4'd4;
   localparam logic [3:0] IP_VERSION_V6 = 4'd6;
   localparam logic [3:0] MIN_IHL = 4'd5;

   // byte positions within the ip header
   localparam int V4_CSUM_POS = 10;
   localparam int V4_SRC_POS = 12;
   localparam int V4_DST_POS = 16;
   localparam int V4_ADDR_END = 20;
   localparam int V6_SRC_POS = 8;
   localparam int V6_DST_POS = 24;
   localparam int V6_ADDR_END = 40;

   // byte offsets within the udp header
   localparam logic [2:0] UDP_SPORT_HI = 3'd0;
   localparam logic [2:0] UDP_DPORT_HI = 3'd2;
   localparam logic [2:0] UDP_LEN_HI = 3'd4;
   localparam logic [2:0] UDP_LEN_LO = 3'd5;
   localparam logic [2:0] UDP_CSUM_HI = 3'd6;
   localparam logic [2:0] UDP_CSUM_LO = 3'd7;

   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef logic [15:0][7:0] addr_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECT   = 2'd1,
      STATUS_LEN_OVER = 2'd2
   } status_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] csum_add(logic [15:0] acc,
                                            logic [ADDEND_WIDTH-1:0] addend);
      logic [ADDEND_WIDTH-1:0] total;
      logic [16:0] part;
      total = ADDEND_WIDTH'(acc) + addend;
      part = {1'b0, total[15:0]} + 17'(total[ADDEND_WIDTH-1:16]);
      return part[15:0] + 16'(part[16]);
   endfunction

   function automatic logic [15:0] byte_word(logic [7:0] b, logic odd);
      return odd ? {8'h00, b} : {b, 8'h00};
   endfunction

   // keeps only the bytes of a header word that lie inside the udp length
   function automatic logic [15:0] masked_word(logic [15:0] w, logic [15:0] dl,
                                               logic [2:0] hi_idx);
      logic keep_hi;
      logic keep_lo;
      keep_hi = dl > 16'(hi_idx);
      keep_lo = dl > (16'(hi_idx) + 16'd1);
      return {w[15:8] & {8{keep_hi}}, w[7:0] & {8{keep_lo}}};
   endfunction

   function automatic logic in_span(pos_type v, int lo, int hi);
      return (v >= POS_WIDTH'(lo)) && (v < POS_WIDTH'(hi));
   endfunction

endpackage

[hdl/udp_address_rewrite_checksum_top.sv]
// one packet byte per transaction; a new byte can be accepted every cycle, unless a last byte waits for the snapshot
// the last byte passes the input register, then the end-of-packet snapshot, then the result register; each can stall
// each byte adds into the header sum and the pseudo-header and datagram sum as it leaves the input register
// synchronous active-high reset empties the pipeline and clears the packet state
`include "assert_macros.svh"

module udp_address_rewrite_checksum_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last,
   input  logic                 req_func,
   input  logic                 req_family,
   input  logic [63:0]          req_addr_high,
   input  logic [63:0]          req_addr_low,
   input  logic [15:0]          req_new_port,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_ip_checksum,
   output logic [15:0]          rsp_udp_checksum,
   output logic [5:0]           rsp_udp_offset,
   output uarc_pkg::status_type rsp_status
);
   import uarc_pkg::*;

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [7:0]  a_byte_ff;
   logic        a_last_ff, a_func_ff, a_family_ff;
   addr_type    a_addr_ff;
   logic [15:0] a_port_ff;

   // packet state
   pos_type     pos_ff, pos_in;
   logic [5:0]  hl_ff, hl_in;
   logic        fault_ff, fault_in;
   logic [15:0] hsum_ff, hsum_in;
   logic [15:0] usum_ff, usum_in;
   logic [15:0] dlen_ff, dlen_in;
   logic        family_ff, family_in;
   logic        func_ff, func_in;
   addr_type    addr_ff, addr_in;
   logic [15:0] nport_ff, nport_in;
   logic [7:0]  pbyte_ff [4];
   logic [7:0]  pbyte_in [4];

   // end-of-packet snapshot
   logic                 f_valid_ff, f_valid_in;
   logic                 f_family_ff, f_fault_ff;
   logic [LEN_WIDTH-1:0] f_len_ff;
   logic [5:0]           f_hl_ff;
   logic [15:0]          f_dlen_ff, f_hsum_ff, f_usum_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_ip_checksum_ff, rsp_ip_checksum_in;
   logic [15:0] rsp_udp_checksum_ff, rsp_udp_checksum_in;
   logic [5:0]  rsp_udp_offset_ff, rsp_udp_offset_in;
   status_type  rsp_status_ff, rsp_status_in;

   // handshake chain
   logic req_accept, r_free, f_move, f_free, a_move;

   // byte processing
   logic                    first, cur_family, cur_func, first_bad, fault_cur, work;
   logic [5:0]              hl_cur;
   pos_type                 rel;
   logic                    in_hdr, in_udph, in_data;
   logic                    hb_sub, hb_zero, in_addr;
   logic [3:0]              idx;
   logic [7:0]              hbyte;
   logic [15:0]             hdr_word, dl_new, w0, w1;
   logic [ADDEND_WIDTH-1:0] u_addend;
   logic [15:0]             hsum_upd, usum_upd, dlen_upd;

   // result stage
   logic [CMP_WIDTH-1:0] len_c;
   logic                 st_reject, st_over;

   assign r_free     = !rsp_valid_ff || rsp_ready;
   assign f_move     = f_valid_ff && r_free;
   assign f_free     = !f_valid_ff || r_free;
   assign a_move     = a_valid_ff && (!a_last_ff || f_free);
   assign req_ready  = !a_valid_ff || a_move;
   assign req_accept = req_valid && req_ready;

   assign a_valid_in   = req_accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
   assign f_valid_in   = (a_move && a_last_ff) ? 1'b1 : (f_move ? 1'b0 : f_valid_ff);
   assign rsp_valid_in = f_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // first byte: header length and version check
   assign first      = (pos_ff == '0);
   assign cur_family = first ? a_family_ff : family_ff;
   assign cur_func   = first ? a_func_ff : func_ff;
   assign hl_cur     = first ? (cur_family ? 6'(V6_HDR_LEN) : {a_byte_ff[3:0], 2'b00})
                             : hl_ff;
   assign first_bad  = first && (cur_family ? (a_byte_ff[7:4] != IP_VERSION_V6)
                                            : (a_byte_ff[7:4] != IP_VERSION_V4 ||
                                               a_byte_ff[3:0] < MIN_IHL));
   assign fault_cur  = fault_ff || first_bad || (pos_ff >= POS_WIDTH'(MAX_PACKET_BYTES));
   assign work       = !fault_cur;

   // packet region of this byte
   assign rel     = pos_ff - POS_WIDTH'(hl_cur);
   assign in_hdr  = pos_ff < POS_WIDTH'(hl_cur);
   assign in_udph = !in_hdr && (rel < POS_WIDTH'(UDP_HDR_BYTES));
   assign in_data = !in_hdr && !in_udph && (CMP_WIDTH'(rel) < CMP_WIDTH'(dlen_ff));

   // address substitution within the ip header
   always_comb begin
      hb_sub  = 1'b0;
      hb_zero = 1'b0;
      in_addr = 1'b0;
      idx     = '0;
      if (!cur_family) begin
         hb_zero = (pos_ff == POS_WIDTH'(V4_CSUM_POS)) ||
                   (pos_ff == POS_WIDTH'(V4_CSUM_POS + 1));
         in_addr = in_span(pos_ff, V4_SRC_POS, V4_ADDR_END);
         if (cur_func) begin
            hb_sub = in_span(pos_ff, V4_SRC_POS, V4_DST_POS);
            idx    = pos_ff[3:0] - 4'(V4_SRC_POS);
         end else begin
            hb_sub = in_span(pos_ff, V4_DST_POS, V4_ADDR_END);
            idx    = pos_ff[3:0] - 4'(V4_DST_POS);
         end
      end else begin
         in_addr = in_span(pos_ff, V6_SRC_POS, V6_ADDR_END);
         if (cur_func) begin
            hb_sub = in_span(pos_ff, V6_SRC_POS, V6_DST_POS);
            idx    = pos_ff[3:0] - 4'(V6_SRC_POS);
         end else begin
            hb_sub = in_span(pos_ff, V6_DST_POS, V6_ADDR_END);
            idx    = pos_ff[3:0] - 4'(V6_DST_POS);
         end
      end
   end

   assign hbyte    = hb_sub ? addr_ff[~idx] : (hb_zero ? 8'h00 : a_byte_ff);
   assign hdr_word = byte_word(hbyte, pos_ff[0]);
   assign dl_new   = {dlen_ff[15:8], a_byte_ff};
   assign w0       = cur_func ? nport_ff : {pbyte_ff[0], pbyte_ff[1]};
   assign w1       = cur_func ? {pbyte_ff[2], pbyte_ff[3]} : nport_ff;

   // addend for the pseudo-header and datagram sum
   always_comb begin
      u_addend = '0;
      if (work) begin
         if (in_hdr) begin
            if (in_addr) begin
               u_addend = ADDEND_WIDTH'(hdr_word);
            end
         end else if (in_udph) begin
            case (rel[2:0])
               UDP_LEN_LO: begin
                  u_addend = ADDEND_WIDTH'(UDP_PROTO) + ADDEND_WIDTH'(dl_new) +
                             ADDEND_WIDTH'(masked_word(dl_new, dl_new, UDP_LEN_HI));
               end
               UDP_CSUM_HI: begin
                  u_addend = ADDEND_WIDTH'(masked_word(w0, dlen_ff, UDP_SPORT_HI));
               end
               UDP_CSUM_LO: begin
                  u_addend = ADDEND_WIDTH'(masked_word(w1, dlen_ff, UDP_DPORT_HI));
               end
               default: begin
                  u_addend = '0;
               end
            endcase
         end else if (in_data) begin
            u_addend = ADDEND_WIDTH'(byte_word(a_byte_ff, rel[0]));
         end
      end
   end

   assign hsum_upd = (work && in_hdr && !cur_family) ? csum_add(hsum_ff, ADDEND_WIDTH'(hdr_word))
                                                     : hsum_ff;
   assign usum_upd = csum_add(usum_ff, u_addend);

   always_comb begin
      dlen_upd = dlen_ff;
      if (work && in_udph) begin
         if (rel[2:0] == UDP_LEN_HI) begin
            dlen_upd[15:8] = a_byte_ff;
         end else if (rel[2:0] == UDP_LEN_LO) begin
            dlen_upd[7:0] = a_byte_ff;
         end
      end
   end

   // packet state update
   always_comb begin
      pos_in    = pos_ff;
      hl_in     = hl_ff;
      fault_in  = fault_ff;
      hsum_in   = hsum_ff;
      usum_in   = usum_ff;
      dlen_in   = dlen_ff;
      family_in = family_ff;
      func_in   = func_ff;
      addr_in   = addr_ff;
      nport_in  = nport_ff;
      for (int i = 0; i < 4; i++) begin
         pbyte_in[i] = pbyte_ff[i];
      end
      if (a_move) begin
         if (first) begin
            family_in = a_family_ff;
            func_in   = a_func_ff;
            addr_in   = a_addr_ff;
            nport_in  = a_port_ff;
            hl_in     = hl_cur;
         end
         fault_in = fault_cur;
         hsum_in  = hsum_upd;
         usum_in  = usum_upd;
         dlen_in  = dlen_upd;
         if (work && in_udph && !rel[2]) begin
            pbyte_in[rel[1:0]] = a_byte_ff;
         end
         if (pos_ff < POS_WIDTH'(MAX_PACKET_BYTES)) begin
            pos_in = pos_ff + 1'b1;
         end
         if (a_last_ff) begin
            pos_in   = '0;
            hl_in    = '0;
            fault_in = 1'b0;
            hsum_in  = '0;
            usum_in  = '0;
            dlen_in  = '0;
         end
      end
   end

   // result from the snapshot
   assign len_c     = CMP_WIDTH'(f_len_ff);
   assign st_reject = f_fault_ff ||
                      len_c < (f_family_ff ? CMP_WIDTH'(MIN_LEN_V6) : CMP_WIDTH'(MIN_LEN_V4)) ||
                      len_c < (CMP_WIDTH'(f_hl_ff) + CMP_WIDTH'(UDP_HDR_BYTES));
   assign st_over   = (CMP_WIDTH'(f_hl_ff) + CMP_WIDTH'(f_dlen_ff)) > len_c;

   always_comb begin
      rsp_status_in       = STATUS_REJECT;
      rsp_ip_checksum_in  = '0;
      rsp_udp_checksum_in = '0;
      rsp_udp_offset_in   = '0;
      if (!st_reject) begin
         rsp_udp_offset_in  = f_hl_ff;
         rsp_ip_checksum_in = f_family_ff ? 16'h0000 : ~f_hsum_ff;
         if (st_over) begin
            rsp_status_in = STATUS_LEN_OVER;
         end else begin
            rsp_status_in       = STATUS_OK;
            rsp_udp_checksum_in = (f_usum_ff == 16'hFFFF) ? 16'hFFFF : ~f_usum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         hl_ff        <= '0;
         fault_ff     <= 1'b0;
         hsum_ff      <= '0;
         usum_ff      <= '0;
         dlen_ff      <= '0;
         family_ff    <= 1'b0;
         func_ff      <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         f_valid_ff   <= f_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         hl_ff        <= hl_in;
         fault_ff     <= fault_in;
         hsum_ff      <= hsum_in;
         usum_ff      <= usum_in;
         dlen_ff      <= dlen_in;
         family_ff    <= family_in;
         func_ff      <= func_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      nport_ff <= nport_in;
      for (int i = 0; i < 4; i++) begin
         pbyte_ff[i] <= pbyte_in[i];
      end
      if (req_accept) begin
         a_byte_ff   <= req_data_byte;
         a_last_ff   <= req_last;
         a_func_ff   <= req_func;
         a_family_ff <= req_family;
         a_addr_ff   <= {req_addr_high, req_addr_low};
         a_port_ff   <= req_new_port;
      end
      if (a_move && a_last_ff) begin
         f_family_ff <= cur_family;
         f_fault_ff  <= fault_cur;
         f_len_ff    <= LEN_WIDTH'(pos_ff) + 1'b1;
         f_hl_ff     <= hl_cur;
         f_dlen_ff   <= dlen_upd;
         f_hsum_ff   <= hsum_upd;
         f_usum_ff   <= usum_upd;
      end
      if (f_move) begin
         rsp_ip_checksum_ff  <= rsp_ip_checksum_in;
         rsp_udp_checksum_ff <= rsp_udp_checksum_in;
         rsp_udp_offset_ff   <= rsp_udp_offset_in;
         rsp_status_ff       <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ip_checksum  = rsp_ip_checksum_ff;
   assign rsp_udp_checksum = rsp_udp_checksum_ff;
   assign rsp_udp_offset   = rsp_udp_offset_ff;
   assign rsp_status       = rsp_status_ff;

   `ASSERT_IMPLIES(a_reject_zero, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_REJECT, rsp_ip_checksum_ff == 16'h0000 && rsp_udp_checksum_ff == 16'h0000 && rsp_udp_offset_ff == 6'd0, "rejected result with nonzero fields")
   `ASSERT_IMPLIES(a_ok_csum, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_OK, rsp_udp_checksum_ff != 16'h0000, "udp checksum of zero sent")
   `ASSERT_NEXT(a_last_clears, clock, reset, a_move && a_last_ff, pos_ff == '0 && fault_ff == 1'b0 && usum_ff == 16'h0000, "packet state not cleared after last byte")
   `ASSERT_NEXT(a_snap_held, clock, reset, f_valid_ff && !r_free, f_valid_ff, "pending snapshot lost")

endmodule
